// File: rtl/pbisp_pkg.sv
// ----------------------------------------------------------------------------
// pbisp_pkg
// Shared types and constants of the parity bit insert / strip packer.
// ----------------------------------------------------------------------------
package pbisp_pkg;

  // mode register codes (bit 1 set selects strip)
  localparam logic [1:0] ModeEvenPar = 2'd0;
  localparam logic [1:0] ModeOddPar  = 2'd1;
  localparam logic [1:0] ModeStrip   = 2'd2;

  // configuration register index
  localparam logic RegMode = 1'b0;

  // position of the dropped bit inside a 9-bit unit
  localparam logic [3:0] UnitDropPos = 4'd8;

  // default depth of the result queue
  localparam int unsigned ResFifoDepth = 4;

  // one result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } res_t;

  // outcome of processing one input byte in either mode
  typedef struct packed {
    logic [1:0] n_res;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [6:0] acc;
    logic [2:0] held;
    logic [3:0] pos;
  } step_t;

endpackage

// File: rtl/pbisp_insert.sv
// ----------------------------------------------------------------------------
// pbisp_insert
// Appends a parity bit to a byte and packs the 9-bit unit into output bytes.
// ----------------------------------------------------------------------------
module pbisp_insert (
  input  logic              odd_par,
  input  logic [7:0]        data_byte,
  input  logic [6:0]        acc,
  input  logic [2:0]        held,
  input  logic [3:0]        pos,
  output pbisp_pkg::step_t  step
);

  logic        par;
  logic [15:0] acc_ext;
  logic [15:0] shifted;
  logic [3:0]  sh_amt;
  logic [2:0]  held_nxt;
  logic [7:0]  keep_mask;

  // parity and merged accumulator
  assign par     = (^data_byte) ^ odd_par;
  assign acc_ext = {acc, data_byte, par};

  // first byte sits just above the bits that stay pending
  assign sh_amt  = {1'b0, held} + 4'd1;
  assign shifted = acc_ext >> sh_amt;

  // pending count grows by one per byte and wraps after a second byte
  assign held_nxt  = held + 3'd1;
  assign keep_mask = (8'd1 << held_nxt) - 8'd1;

  always_comb begin
    step.n_res = (held == 3'd7) ? 2'd2 : 2'd1;
    step.byte0 = shifted[7:0];
    step.byte1 = acc_ext[7:0];
    step.acc   = acc_ext[6:0] & keep_mask[6:0];
    step.held  = held_nxt;
    step.pos   = pos;
  end

endmodule

// File: rtl/pbisp_strip.sv
// ----------------------------------------------------------------------------
// pbisp_strip
// Drops every ninth bit of the packed stream and regathers the data bytes.
// ----------------------------------------------------------------------------
module pbisp_strip (
  input  logic [7:0]        data_byte,
  input  logic [6:0]        acc,
  input  logic [2:0]        held,
  input  logic [3:0]        pos,
  output pbisp_pkg::step_t  step
);

  // walk the eight bits msb first
  always_comb begin
    logic [7:0] a;
    logic [3:0] h;
    logic [3:0] p;
    logic [7:0] b0;
    logic       got;
    a   = {1'b0, acc};
    h   = {1'b0, held};
    p   = (pos > pbisp_pkg::UnitDropPos) ? 4'd0 : pos;
    b0  = 8'd0;
    got = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (p == pbisp_pkg::UnitDropPos) begin
        // parity bit of the unit is skipped unchecked
        p = 4'd0;
      end else begin
        p = p + 4'd1;
        a = {a[6:0], data_byte[3'(7 - i)]};
        h = h + 4'd1;
        if (h == 4'd8) begin
          b0  = a;
          got = 1'b1;
          a   = 8'd0;
          h   = 4'd0;
        end
      end
    end
    step.n_res = {1'b0, got};
    step.byte0 = b0;
    step.byte1 = 8'd0;
    step.acc   = a[6:0];
    step.held  = h[2:0];
    step.pos   = p;
  end

endmodule

// File: rtl/pbisp_res_fifo.sv
// ----------------------------------------------------------------------------
// pbisp_res_fifo
// Result queue taking up to two transactions per cycle and giving one.
// ----------------------------------------------------------------------------
module pbisp_res_fifo #(
  parameter int unsigned DEPTH = pbisp_pkg::ResFifoDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  pbisp_pkg::res_t   push_res0,
  input  pbisp_pkg::res_t   push_res1,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output pbisp_pkg::res_t   out_res
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] SpaceLim = CntW'(DEPTH - 2);

  pbisp_pkg::res_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PtrW-1:0] wr_ptr_p2;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  // wrap helpers
  assign wr_ptr_p1 = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
  assign wr_ptr_p2 = (wr_ptr_p1 == PtrLast) ? '0 : wr_ptr_p1 + PtrW'(1);

  assign pop       = out_valid & out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign space_ok  = (count_r <= SpaceLim);

  // pointer and count update
  always_comb begin
    unique case (push_n)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = wr_ptr_p2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    end
    count_nxt = count_r + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_res0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_res1;
    end
  end

endmodule

// File: rtl/parity_bit_insert_strip_packer_unit.sv
// ----------------------------------------------------------------------------
// parity_bit_insert_strip_packer_unit
// Byte stream parity bit inserter / stripper with 9-bit unit packing.
// ----------------------------------------------------------------------------
// The unit takes one input byte per cycle. Each byte is processed in the
// cycle it is accepted: the shift-and-merge of the bit accumulator is one
// level of logic, so the pending bits are ready for the next byte at once.
// Results go through a small queue that accepts up to two transactions per
// cycle and returns one per cycle, so insert modes (nine result bytes per
// eight input bytes) run at the pace of the result port, while strip mode
// runs at one input byte per cycle. The input is held off only while the
// queue has fewer than two free entries. Mode is written through the
// register port at byte addresses 0 to 3 while the unit is idle, a rule
// the unit leaves to the user; a stream end discards partial bits.
// ----------------------------------------------------------------------------
module parity_bit_insert_strip_packer_unit #(
  parameter int unsigned RES_DEPTH = pbisp_pkg::ResFifoDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_run_last,
  output logic        out_stream_done,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]       mode_r;
  logic [6:0]       acc_r;
  logic [2:0]       held_r;
  logic [3:0]       pos_r;
  logic             in_acc;
  logic             mode_wr;
  pbisp_pkg::step_t ins_step, strip_step, step_sel;
  pbisp_pkg::res_t  res0, res1, res_head;
  logic [1:0]       push_n;

  // register port
  assign pready  = 1'b1;
  assign mode_wr = psel & penable & pwrite & (paddr[2] == pbisp_pkg::RegMode);
  assign prdata  = (paddr[2] == pbisp_pkg::RegMode) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pbisp_pkg::ModeEvenPar;
    end else if (mode_wr) begin
      mode_r <= pwdata[1:0];
    end
  end

  // per-mode datapaths
  pbisp_insert u_insert (
    .odd_par   (mode_r == pbisp_pkg::ModeOddPar),
    .data_byte (in_data_byte),
    .acc       (acc_r),
    .held      (held_r),
    .pos       (pos_r),
    .step      (ins_step)
  );

  pbisp_strip u_strip (
    .data_byte (in_data_byte),
    .acc       (acc_r),
    .held      (held_r),
    .pos       (pos_r),
    .step      (strip_step)
  );

  assign step_sel = mode_r[1] ? strip_step : ins_step;
  assign in_acc   = in_valid & in_ready;

  // accumulator state, cleared at stream end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
      pos_r  <= '0;
    end else if (in_acc) begin
      if (in_stream_end) begin
        acc_r  <= '0;
        held_r <= '0;
        pos_r  <= '0;
      end else begin
        acc_r  <= step_sel.acc;
        held_r <= step_sel.held;
        pos_r  <= step_sel.pos;
      end
    end
  end

  // result transactions for this byte
  always_comb begin
    push_n           = in_acc ? step_sel.n_res : 2'd0;
    res0.out_byte    = step_sel.byte0;
    res0.run_last    = (step_sel.n_res == 2'd1);
    res0.stream_done = (step_sel.n_res == 2'd1) & in_stream_end;
    res1.out_byte    = step_sel.byte1;
    res1.run_last    = 1'b1;
    res1.stream_done = in_stream_end;
  end

  pbisp_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_res0 (res0),
    .push_res1 (res1),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res_head)
  );

  assign out_out_byte    = res_head.out_byte;
  assign out_run_last    = res_head.run_last;
  assign out_stream_done = res_head.stream_done;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the parity bit insert / strip packer unit.
// ----------------------------------------------------------------------------
// A queue of stream bytes feeds a valid/ready driver, and a monitor checks
// each result transaction against bytes predicted at input acceptance. The
// mode register is written over the register port between phases, only
// once every predicted byte has come back. A short directed part covers the
// extreme bytes, all four mode codes, a stream end that yields no result, a
// mode change mid-stream and a write to an unused address. Random phases
// then send mostly well-formed streams (eight bytes per insert run, nine
// per strip group) mixed with broken and short ones. Random idling on both
// sides, one long receiver hold-off and one phase with no idling at all
// exercise back-pressure.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] ModeStripAlias = pbisp_pkg::ModeStrip | pbisp_pkg::ModeOddPar;
  localparam logic [2:0] ModeAddr       = {pbisp_pkg::RegMode, 2'b00};
  localparam logic [2:0] SpareAddr      = 3'd4;
  localparam int         ItemsTarget    = 1450;
  localparam int         IdlePct        = 23;
  localparam int         SettleCycles   = 4;
  localparam int         HoldCycles     = 120;
  localparam int         WatchdogLimit  = 3000;
  localparam int         MaxReports     = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_stream_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_run_last;
  logic        out_stream_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  stream_item_t      pending_bytes[$];
  stream_item_t      next_item;
  pbisp_pkg::res_t   expected_bytes[$];
  pbisp_pkg::res_t   want;

  // predictor state
  logic [1:0]  mode_q;
  logic [15:0] acc_q;
  logic [3:0]  held_q;
  logic [3:0]  pos_q;

  bit no_idle  = 1'b0;
  bit hold_go  = 1'b0;
  bit rx_stall = 1'b0;
  int n_errors = 0;
  int n_in_taken = 0;
  int quiet_cycles = 0;

  parity_bit_insert_strip_packer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_stream_end   (in_stream_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock and reset
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    n_errors++;
    if (n_errors <= MaxReports)
      $display("mismatch: %s got %02h expected %02h", what, got, exp_val);
  endtask

  // work out the result bytes caused by one accepted input byte
  task automatic predict_packing(input logic [7:0] din, input logic last_in);
    logic [7:0]      got [0:1];
    logic [15:0]     acc;
    logic [4:0]      held;
    logic [3:0]      pos;
    logic            par;
    pbisp_pkg::res_t r;
    int              n;
    int              b;
    int              k;
    n = 0;
    if (!mode_q[1]) begin
      // insert: append parity, emit whole bytes from the top
      par = ^din;
      if (mode_q == pbisp_pkg::ModeOddPar) par = ~par;
      acc  = {acc_q[6:0], din, par};
      held = 5'(held_q[2:0]) + 5'd9;
      while (held >= 5'd8) begin
        got[n] = 8'(acc >> (held - 5'd8));
        n++;
        held -= 5'd8;
      end
      acc_q  = acc & ((16'd1 << held) - 16'd1);
      held_q = held[3:0];
    end else begin
      // strip: drop the ninth bit of every unit
      held = 5'(held_q[2:0]);
      acc  = acc_q & 16'h007F;
      pos  = (pos_q > pbisp_pkg::UnitDropPos) ? 4'd0 : pos_q;
      for (b = 7; b >= 0; b--) begin
        if (pos == pbisp_pkg::UnitDropPos) begin
          pos = 4'd0;
        end else begin
          pos++;
          acc = ((acc << 1) | 16'(din[b])) & 16'h00FF;
          held++;
          if (held == 5'd8) begin
            if (n < 2) begin
              got[n] = acc[7:0];
              n++;
            end
            acc  = 16'd0;
            held = 5'd0;
          end
        end
      end
      acc_q  = acc;
      held_q = held[3:0];
      pos_q  = pos;
    end
    for (k = 0; k < n; k++) begin
      r.out_byte    = got[k];
      r.run_last    = (k == n - 1);
      r.stream_done = (k == n - 1) && last_in;
      expected_bytes.push_back(r);
    end
    // stream end discards the partial bits
    if (last_in) begin
      acc_q  = 16'd0;
      held_q = 4'd0;
      pos_q  = 4'd0;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
        next_item = pending_bytes.pop_front();
        in_valid      <= 1'b1;
        in_data_byte  <= next_item.data;
        in_stream_end <= next_item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rx_stall) out_ready <= 1'b0;
    else if (no_idle) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= IdlePct);
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_stall <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_stall <= 1'b0;
  end

  // monitor: register writes, input transactions, result checks
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = pbisp_pkg::ModeEvenPar;
      acc_q  = 16'd0;
      held_q = 4'd0;
      pos_q  = 4'd0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ModeAddr)
        mode_q = pwdata[1:0];
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_out_byte !== want.out_byte)
            report_mismatch("out_byte", out_out_byte, want.out_byte);
          if (out_run_last !== want.run_last)
            report_mismatch("run_last", 8'(out_run_last), 8'(want.run_last));
          if (out_stream_done !== want.stream_done)
            report_mismatch("stream_done", 8'(out_stream_done), 8'(want.stream_done));
        end
      end
      if (in_valid && in_ready) begin
        n_in_taken++;
        predict_packing(in_data_byte, in_stream_end);
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL parity_bit_insert_strip_packer_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] data, input logic last);
    stream_item_t it;
    it.data = data;
    it.last = last;
    pending_bytes.push_back(it);
  endtask

  // wait until every byte is taken and every result is back
  task automatic drain();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    reg_write(ModeAddr, ($urandom & 32'hFFFF_FFFC) | 32'(m));
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // random phase: mostly whole runs or groups, some broken and short streams
  task automatic queue_random_phase(input int budget, input logic [1:0] m,
                                    output int queued);
    int unit_len;
    int len;
    int r;
    int i;
    bit close;
    int count;
    unit_len = m[1] ? 9 : 8;
    count = 0;
    while (count < budget) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = unit_len * $urandom_range(1, 3);
        close = 1'b1;
      end else if (r < 88) begin
        len = $urandom_range(1, 13);
        close = ($urandom_range(1) != 0);
      end else begin
        len = $urandom_range(1, 3);
        close = 1'b1;
      end
      for (i = 0; i < len; i++)
        queue_byte(rand_byte(), close && (i == len - 1));
      count += len;
    end
    queued = count;
  endtask

  // main sequence
  initial begin
    int total;
    int phase;
    int budget;
    int queued;
    logic [1:0] cur_mode;
    logic [1:0] extremes [0:3];
    extremes[0] = pbisp_pkg::ModeEvenPar;
    extremes[1] = ModeStripAlias;
    extremes[2] = pbisp_pkg::ModeOddPar;
    extremes[3] = pbisp_pkg::ModeStrip;
    wait (rst_n);
    @(negedge clk);

    // even parity straight after reset, extreme bytes, partial bits dropped
    queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0); queue_byte(8'h7F, 1'b0); queue_byte(8'hFE, 1'b0);
    queue_byte(8'hA5, 1'b0); queue_byte(8'h3C, 1'b0); queue_byte(8'h5A, 1'b1);
    drain();

    // odd parity
    set_mode(pbisp_pkg::ModeOddPar);
    queue_byte(8'hFF, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h81, 1'b0);
    queue_byte(8'h13, 1'b1);
    drain();

    // strip: a stream end with no result, then an open stream
    set_mode(pbisp_pkg::ModeStrip);
    queue_byte(8'hAB, 1'b0); queue_byte(8'hCD, 1'b1);
    queue_byte(8'h81, 1'b0); queue_byte(8'h7E, 1'b0); queue_byte(8'hC3, 1'b0);
    drain();

    // mode change mid-stream keeps the pending bits
    set_mode(pbisp_pkg::ModeEvenPar);
    queue_byte(8'h24, 1'b0); queue_byte(8'hE7, 1'b1);
    drain();

    // unused address is ignored, mode three acts as strip
    reg_write(SpareAddr, $urandom);
    set_mode(ModeStripAlias);
    queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'h5A, 1'b1);
    drain();
    cur_mode = ModeStripAlias;

    total = 23;
    phase = 0;
    while (total < ItemsTarget) begin
      if (phase < 4) begin
        cur_mode = extremes[phase];
        set_mode(cur_mode);
      end else if ($urandom_range(3) != 0) begin
        cur_mode = 2'($urandom_range(3));
        set_mode(cur_mode);
      end
      if ($urandom_range(15) == 0) reg_write(SpareAddr, $urandom);
      budget = (phase == 2 || phase == 5) ? 200 : $urandom_range(20, 160);
      if (budget > ItemsTarget - total) budget = ItemsTarget - total;
      no_idle = (phase == 5);
      queue_random_phase(budget, cur_mode, queued);
      if (phase == 2) hold_go = 1'b1;
      total += queued;
      drain();
      phase++;
    end
    no_idle = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (n_errors == 0 && expected_bytes.size() == 0) begin
      $display("PASS parity_bit_insert_strip_packer_unit");
    end else begin
      $display("FAIL parity_bit_insert_strip_packer_unit");
    end
    $finish;
  end

endmodule
